FILE: rtl/lpmrt_pkg.sv
// ----------------------------------------------------------------------------
// lpmrt_pkg
// Types, codes and helpers shared by the IPv4 longest-prefix-match forwarder.
// ----------------------------------------------------------------------------
package lpmrt_pkg;

    // Default table depth
    localparam int ROUTE_ENTRIES_DEF = 16;

    // Longest prefix an entry can hold
    localparam logic [5:0] MAX_PREFIX = 6'd32;

    // Request kinds
    localparam logic REQ_ADD     = 1'b0;
    localparam logic REQ_FORWARD = 1'b1;

    // Response status codes
    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_FORWARDED = 3'd2;
    localparam logic [2:0] ST_EXPIRED   = 3'd3;
    localparam logic [2:0] ST_NO_ROUTE  = 3'd4;

    typedef struct packed {
        logic        req_type;
        logic [31:0] route_network;
        logic [5:0]  route_prefix;
        logic [31:0] route_next_hop;
        logic [31:0] dest_addr;
        logic [7:0]  packet_ttl;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] forward_next_hop;
        logic [7:0]  forward_ttl;
    } t_rsp;

    typedef struct packed {
        logic [31:0] network;
        logic [5:0]  prefix;
        logic [31:0] gateway;
    } t_entry;

    // Netmask for a prefix length of 0..32
    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        prefix_mask = ~(32'hFFFF_FFFF >> len);
    endfunction

endpackage

FILE: rtl/lpm_route_table_forwarder.sv
// ----------------------------------------------------------------------------
// lpm_route_table_forwarder
// Small IPv4 route table with add and longest-prefix-match forward requests.
// ----------------------------------------------------------------------------
// An add request stores (network, prefix, next hop) in the next free slot and
// answers ADDED, or FULL once ROUTE_ENTRIES slots are used; prefixes above 32
// are stored as 32. A forward request with TTL 0 or 1 answers EXPIRED.
// Otherwise the sequencer walks the stored entries through one compare unit,
// one entry per cycle out of the table memory (one write port, one registered
// read port), keeping the longest match, first stored winning ties.
// The answer is FORWARDED with the next hop and TTL - 1, or NO_ROUTE.
// o_req_ready is high only while the sequencer is idle; a finished response
// sits in an output register, so the next request can be taken while it
// waits for i_rsp_ready.
// There is no clearing pass: the fill count guards the unwritten slots.
// ----------------------------------------------------------------------------
module lpm_route_table_forwarder
    import lpmrt_pkg::*;
#(
    parameter int ROUTE_ENTRIES = ROUTE_ENTRIES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    localparam int CNT_W = $clog2(ROUTE_ENTRIES + 1);
    localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    // Route table memory
    t_entry mem [ROUTE_ENTRIES];

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx,   n_idx;
    logic             r_rd_vld, n_rd_vld;
    t_entry           r_rd;
    logic [31:0]      r_dest,  n_dest;
    logic [7:0]       r_ttl,   n_ttl;
    logic             r_found, n_found;
    logic [5:0]       r_best_len, n_best_len;
    logic [31:0]      r_best_hop, n_best_hop;
    t_rsp             r_res,   n_res;
    logic             r_rsp_valid, n_rsp_valid;
    t_rsp             r_rsp;

    logic   mem_we;
    t_entry mem_wdata;
    logic   rd_en;
    logic   hit;
    logic   rsp_load;
    logic   table_full;

    assign table_full  = (r_count == CNT_W'(ROUTE_ENTRIES));
    assign rd_en       = (r_state == S_WALK) && (r_idx < r_count);
    // one compare unit: masked XOR of destination against the read entry
    assign hit         = ((r_dest ^ r_rd.network) & prefix_mask(r_rd.prefix)) == 32'd0;
    assign rsp_load    = (r_state == S_FIN) && (!r_rsp_valid || i_rsp_ready);

    assign mem_wdata.network  = i_req.route_network;
    assign mem_wdata.prefix   = (i_req.route_prefix > MAX_PREFIX) ? MAX_PREFIX
                                                                  : i_req.route_prefix;
    assign mem_wdata.gateway  = i_req.route_next_hop;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_rd_vld   = 1'b0;
        n_dest     = r_dest;
        n_ttl      = r_ttl;
        n_found    = r_found;
        n_best_len = r_best_len;
        n_best_hop = r_best_hop;
        n_res      = r_res;
        mem_we     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_res = '0;
                    if (i_req.req_type == REQ_ADD) begin
                        if (table_full) begin
                            n_res.status = ST_FULL;
                        end else begin
                            mem_we       = 1'b1;
                            n_count      = r_count + CNT_W'(1);
                            n_res.status = ST_ADDED;
                        end
                        n_state = S_FIN;
                    end else begin
                        n_dest = i_req.dest_addr;
                        n_ttl  = i_req.packet_ttl - 8'd1;
                        if (i_req.packet_ttl <= 8'd1) begin
                            n_res.status = ST_EXPIRED;
                            n_state      = S_FIN;
                        end else begin
                            n_idx      = '0;
                            n_found    = 1'b0;
                            n_best_len = '0;
                            n_best_hop = '0;
                            n_state    = S_WALK;
                        end
                    end
                end
            end
            S_WALK: begin
                // read stage: one entry address per cycle
                if (rd_en) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                n_rd_vld = rd_en;
                // compare stage: strictly longer wins, so first match keeps ties
                if (r_rd_vld && hit && (!r_found || r_rd.prefix > r_best_len)) begin
                    n_found    = 1'b1;
                    n_best_len = r_rd.prefix;
                    n_best_hop = r_rd.gateway;
                end
                if (!rd_en && !r_rd_vld) begin
                    if (r_found) begin
                        n_res.status           = ST_FORWARDED;
                        n_res.forward_next_hop = r_best_hop;
                        n_res.forward_ttl      = r_ttl;
                    end else begin
                        n_res = '0;
                        n_res.status = ST_NO_ROUTE;
                    end
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (rsp_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_rsp_valid = rsp_load || (r_rsp_valid && !i_rsp_ready);
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_count[IDX_W-1:0]] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd <= mem[r_idx[IDX_W-1:0]];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_vld    <= n_rd_vld;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_dest     <= n_dest;
        r_ttl      <= n_ttl;
        r_found    <= n_found;
        r_best_len <= n_best_len;
        r_best_hop <= n_best_hop;
        r_res      <= n_res;
        if (rsp_load) begin
            r_rsp <= r_res;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

FILE: rtl/lpmrt_checker.sv
// ----------------------------------------------------------------------------
// lpmrt_checker
// Port-level assertions for the route table forwarder, bound to the top level.
// ----------------------------------------------------------------------------
module lpmrt_checker
    import lpmrt_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic o_req_ready,
    input t_req i_req,
    input logic o_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp o_rsp
);

    // no response comes out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("response valid right after reset");

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled response changed");

    // one request at a time: busy right after acceptance
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request taken while busy");

    // only a forwarded packet carries a next hop and TTL
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status != ST_FORWARDED |->
            o_rsp.forward_next_hop == 32'd0 && o_rsp.forward_ttl == 8'd0)
        else $error("non-forward response with nonzero fields");

    // a forwarded packet never leaves with TTL zero
    a_fwd_ttl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status == ST_FORWARDED |-> o_rsp.forward_ttl != 8'd0)
        else $error("forwarded packet with expired TTL");

endmodule

bind lpm_route_table_forwarder lpmrt_checker u_lpmrt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .i_req       (i_req),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);
